[rtl/adp_pkg.sv]
// shared types, constants and the prefix-code packing function
package adp_pkg;

  localparam logic [3:0] TopBit     = 4'd15;
  localparam logic [1:0] MaxHeld    = 2'd3;
  localparam int         MaxResults = 4;
  localparam int         NumSlots   = 10;
  localparam logic [15:0] EmptyWord = 16'h8000;

  localparam logic [3:0] LenRun  = 4'd1;
  localparam logic [3:0] LenZero = 4'd2;
  localparam logic [3:0] LenP1   = 4'd3;
  localparam logic [3:0] LenM1   = 4'd4;
  localparam logic [3:0] LenP2   = 4'd5;
  localparam logic [3:0] LenM2   = 4'd6;
  localparam logic [3:0] LenP3   = 4'd7;
  localparam logic [3:0] LenM3   = 4'd8;

  // candidate result positions, in emission order
  localparam int SlotDrain     = 0;
  localparam int SlotCode      = 3;
  localparam int SlotFlush     = 4;
  localparam int SlotRaw       = 5;
  localparam int SlotLastDrain = 6;
  localparam int SlotFinal     = 9;

  typedef struct packed {
    logic signed [14:0] sample;
    logic               block_last;
  } item_t;

  typedef struct packed {
    logic [15:0] code_word;
    logic        run_last;
    logic        block_end;
  } result_t;

  typedef struct packed {
    logic [MaxResults-1:0][15:0] words;
    logic [2:0]                  count;
    logic                        block_end;
  } enc_res_t;

  typedef struct packed {
    logic [15:0] word;
    logic [3:0]  nb;
    logic        flush;
    logic [15:0] out;
  } pc_res_t;

  function automatic pc_res_t put_code(logic [15:0] w, logic [3:0] nb, logic [3:0] len);
    pc_res_t    r;
    logic [3:0] nnb;
    r.out = w;
    if (nb >= len) begin
      nnb     = nb - len;
      r.word  = w | (16'd1 << nnb);
      r.flush = 1'b0;
    end else begin
      nnb     = TopBit - len;
      r.word  = EmptyWord | (16'd1 << nnb);
      r.flush = 1'b1;
    end
    r.nb = nnb;
    return r;
  endfunction

endpackage

[rtl/adc_delta_prefix_encoder.sv]
// top level of the delta prefix coder for adc sample streams
// An item passes through an input register and is coded combinationally into up to
// four 16-bit words, which a result register then hands out one per cycle while the
// output is ready. The first word is offered once the item has moved from the input
// register into the result register. An item giving one word (or none) leaves the
// input side free, so samples flow at one per cycle while the output is ready; an item
// that gives more words holds the input side until its last word is taken.
module adc_delta_prefix_encoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  adp_pkg::item_t   in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output adp_pkg::result_t out_item_o
);
  import adp_pkg::*;

  logic     inq_valid_q;
  item_t    inq_item_q;
  logic     can_load;
  logic     take;
  enc_res_t enc_res;

  assign take       = inq_valid_q && can_load;
  assign in_ready_o = !inq_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      inq_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      inq_item_q <= in_item_i;
    end
  end

  adp_encode u_encode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (take),
    .item_i    (inq_item_q),
    .res_o     (enc_res)
  );

  adp_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_i       (enc_res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[rtl/adp_encode.sv]
// encoder state and single-pass coding of one item into up to four words
module adp_encode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  input  adp_pkg::item_t item_i,
  output adp_pkg::enc_res_t res_o
);
  import adp_pkg::*;

  logic signed [14:0] prev_q, prev_d;
  logic [15:0]        word_q, word_d;
  logic [3:0]         nb_q, nb_d;
  logic [1:0]         pz_q, pz_d;
  logic               start_q, start_d;

  logic [NumSlots-1:0]        slot_v;
  logic [NumSlots-1:0][15:0]  slot_w;
  logic signed [15:0]         d;
  logic [15:0]                neg;
  logic [13:0]                mag;
  logic [15:0]                raw_word;
  logic [3:0]                 len;
  logic                       in_band;

  assign d       = {item_i.sample[14], item_i.sample} - {prev_q[14], prev_q};
  assign in_band = (d >= -16'sd3) && (d <= 16'sd3);
  assign neg     = -{item_i.sample[14], item_i.sample};
  assign mag     = (item_i.sample == 15'sh4000) ? 14'h3fff : neg[13:0];
  assign raw_word = (item_i.sample > 15'sd0) ? {1'b0, item_i.sample} : {2'b01, mag};

  always_comb begin
    unique case (d)
      16'sd1:  len = LenP1;
      -16'sd1: len = LenM1;
      16'sd2:  len = LenP2;
      -16'sd2: len = LenM2;
      16'sd3:  len = LenP3;
      default: len = LenM3;
    endcase
  end

  always_comb begin
    pc_res_t    r;
    logic [2:0] cnt;
    word_d  = word_q;
    nb_d    = nb_q;
    pz_d    = pz_q;
    start_d = start_q;
    prev_d  = item_i.sample;
    slot_v  = '0;
    slot_w  = '0;
    r       = '0;

    if (start_q) begin
      slot_v[SlotRaw] = 1'b1;
      slot_w[SlotRaw] = {item_i.sample[14], item_i.sample};
      start_d         = 1'b0;
    end else if (d == 16'sd0) begin
      if (pz_q == MaxHeld) begin
        r                = put_code(word_d, nb_d, LenRun);
        word_d           = r.word;
        nb_d             = r.nb;
        slot_v[SlotCode] = r.flush;
        slot_w[SlotCode] = r.out;
        pz_d             = 2'd0;
      end else begin
        pz_d = pz_q + 2'd1;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < pz_q) begin
          r                     = put_code(word_d, nb_d, LenZero);
          word_d                = r.word;
          nb_d                  = r.nb;
          slot_v[SlotDrain + i] = r.flush;
          slot_w[SlotDrain + i] = r.out;
        end
      end
      pz_d = 2'd0;
      if (in_band) begin
        r                = put_code(word_d, nb_d, len);
        word_d           = r.word;
        nb_d             = r.nb;
        slot_v[SlotCode] = r.flush;
        slot_w[SlotCode] = r.out;
      end else begin
        slot_v[SlotFlush] = (nb_d != TopBit);
        slot_w[SlotFlush] = word_d;
        word_d            = EmptyWord;
        nb_d              = TopBit;
        slot_v[SlotRaw]   = 1'b1;
        slot_w[SlotRaw]   = raw_word;
      end
    end

    if (item_i.block_last) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < pz_d) begin
          r                         = put_code(word_d, nb_d, LenZero);
          word_d                    = r.word;
          nb_d                      = r.nb;
          slot_v[SlotLastDrain + i] = r.flush;
          slot_w[SlotLastDrain + i] = r.out;
        end
      end
      slot_v[SlotFinal] = 1'b1;
      slot_w[SlotFinal] = word_d;
      word_d            = EmptyWord;
      nb_d              = TopBit;
      pz_d              = 2'd0;
      start_d           = 1'b1;
    end

    // pack the emitted words in order, keeping at most four
    res_o.words = '0;
    cnt         = 3'd0;
    for (int i = 0; i < NumSlots; i++) begin
      if (slot_v[i] && (cnt < 3'(MaxResults))) begin
        res_o.words[cnt[1:0]] = slot_w[i];
        cnt                   = cnt + 3'd1;
      end
    end
    res_o.count     = cnt;
    res_o.block_end = item_i.block_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      word_q  <= EmptyWord;
      nb_q    <= TopBit;
      pz_q    <= '0;
      start_q <= 1'b1;
    end else if (advance_i) begin
      prev_q  <= prev_d;
      word_q  <= word_d;
      nb_q    <= nb_d;
      pz_q    <= pz_d;
      start_q <= start_d;
    end
  end

endmodule

[rtl/adp_obuf.sv]
// result register holding the words of one item and handing them out in order
module adp_obuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  adp_pkg::enc_res_t  res_i,
  output logic               can_load_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output adp_pkg::result_t   out_item_o
);
  import adp_pkg::*;

  logic [MaxResults-1:0][15:0] words_q;
  logic [2:0]                  cnt_q, cnt_d;
  logic [1:0]                  rd_q, rd_d;
  logic                        be_q;
  logic                        at_last;
  logic                        pop;

  assign out_valid_o = (cnt_q != 3'd0);
  assign at_last     = ({1'b0, rd_q} == (cnt_q - 3'd1));
  assign pop         = out_valid_o && out_ready_i;
  assign can_load_o  = !out_valid_o || (pop && at_last);

  assign out_item_o.code_word = words_q[rd_q];
  assign out_item_o.run_last  = at_last;
  assign out_item_o.block_end = be_q && at_last;

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (load_i) begin
      cnt_d = res_i.count;
      rd_d  = 2'd0;
    end else if (pop) begin
      if (at_last) begin
        cnt_d = 3'd0;
        rd_d  = 2'd0;
      end else begin
        rd_d = rd_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      words_q <= res_i.words;
      be_q    <= res_i.block_end;
    end
  end

endmodule
